@@ sv/fau_pkg.sv @@
// Package of the fraction arithmetic unit: operation codes, verdict codes,
// result width and the command and status records between controller and datapath.
// Depends on nothing; every other file of the unit imports it.
`timescale 1ns / 1ps
`default_nettype none

package fau_pkg;

  // Width of the result numerator and denominator.
  localparam int unsigned RES_W = 33;

  // Operation codes carried by the mode field.
  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_CDN = 3'd4,
    MODE_RED = 3'd5,
    MODE_SGN = 3'd6,
    MODE_CMP = 3'd7
  } mode_e;

  // Verdict codes of the test operations.
  localparam logic [1:0] VERD_REDUCED     = 2'd0;
  localparam logic [1:0] VERD_NOT_REDUCED = 2'd1;
  localparam logic [1:0] VERD_NEGATIVE    = 2'd0;
  localparam logic [1:0] VERD_NOT_NEG     = 2'd1;
  localparam logic [1:0] VERD_GREATER     = 2'd0;
  localparam logic [1:0] VERD_LESS        = 2'd1;
  localparam logic [1:0] VERD_EQUAL       = 2'd2;
  localparam logic [1:0] VERD_NONE        = 2'd0;

  // Product slots of the shared multiplier.
  localparam logic [1:0] PSEL_0 = 2'd0;
  localparam logic [1:0] PSEL_1 = 2'd1;
  localparam logic [1:0] PSEL_2 = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture a new transaction's operands
    logic       mul_en;    // form one product and store it
    logic [1:0] mul_sel;   // which product slot
    logic       div_step;  // one bit of the remainder division
    logic       gcd_next;  // move to the next Euclid pair
    logic       finish;    // register the result and raise the strobe
  } fau_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_e mode;      // operation of the current transaction
    logic  b_zero;    // second Euclid operand is zero
    logic  rem_zero;  // remainder just formed is zero
  } fau_stat_t;

endpackage

`default_nettype wire

@@ sv/fau_ctrl.sv @@
// Controller of the fraction arithmetic unit: sequences the multiplier steps
// and the Euclid remainder loop. Depends on fau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fau_ctrl #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [2:0]         mode_i,
  input  wire fau_pkg::fau_stat_t stat_i,
  output logic                    busy_o,
  output fau_pkg::fau_cmd_t       cmd_o
);
  import fau_pkg::*;

  localparam int unsigned CW = $clog2(OPERAND_WIDTH);
  localparam logic [CW-1:0] DIV_LAST = CW'(OPERAND_WIDTH - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_NEXT = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    mul_last;
  logic          accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Number of products each operation needs, given as the last slot index.
  always_comb begin
    unique case (stat_i.mode) inside
      MODE_ADD, MODE_SUB: mul_last = PSEL_2;
      MODE_SGN:           mul_last = PSEL_0;
      default:            mul_last = PSEL_1;
    endcase
  end

  // Next state, step counter and commands.
  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    cmd_o            = '0;
    cmd_o.load       = accept;
    cmd_o.mul_sel    = cnt_q[1:0];
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          state_d = (mode_e'(mode_i) == MODE_RED) ? ST_CHK : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q[1:0] == mul_last) begin
          state_d = ST_FIN;
        end
      end
      ST_CHK: begin
        cnt_d   = '0;
        state_d = stat_i.b_zero ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        cmd_o.gcd_next = 1'b1;
        cnt_d          = '0;
        state_d        = stat_i.rem_zero ? ST_FIN : ST_DIV;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/fau_dp.sv @@
// Datapath of the fraction arithmetic unit: operand registers, one shared
// signed multiplier, a bit-serial remainder unit for Euclid and the result
// registers. Depends on fau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fau_dp #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire fau_pkg::fau_cmd_t            cmd_i,
  input  wire logic [2:0]                   mode_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] x_num_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] x_den_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] y_num_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] y_den_i,
  output fau_pkg::fau_stat_t                stat_o,
  output logic                              done_o,
  output logic signed [fau_pkg::RES_W-1:0]  res_num_o,
  output logic signed [fau_pkg::RES_W-1:0]  res_den_o,
  output logic [1:0]                        verdict_o
);
  import fau_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned SW = (PW + 1 > RES_W) ? PW + 1 : RES_W;

  // Operand registers.
  mode_e               mode_q;
  logic signed [W-1:0] xn_q, xd_q, yn_q, yd_q;

  // Multiplier and product slots.
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] p0_q, p1_q, p2_q;

  // Euclid registers: magnitudes and signs kept apart.
  logic [W-1:0] ga_mag_q, gb_mag_q, rem_q, ash_q;
  logic         ga_neg_q, gb_neg_q;
  logic [W-1:0] xn_mag, xd_mag;
  logic [W:0]   cand, cand_sub;
  logic         cand_ge;

  // Result registers.
  logic signed [RES_W-1:0] res_num_q, res_den_q;
  logic [1:0]              verdict_q;
  logic                    done_q;

  // Result arithmetic.
  logic [SW-1:0]           p0_ext, p1_ext, p2_ext, sum_ext, dif_ext;
  logic signed [RES_W-1:0] num_d, den_d;
  logic [1:0]              verdict_d;

  assign stat_o.mode     = mode_q;
  assign stat_o.b_zero   = (gb_mag_q == '0);
  assign stat_o.rem_zero = (rem_q == '0);

  // Operand capture at the accepting edge.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_e'(mode_i);
      xn_q   <= x_num_i;
      xd_q   <= x_den_i;
      yn_q   <= y_num_i;
      yd_q   <= y_den_i;
    end
  end

  // Multiplier operand selection by operation and product slot.
  always_comb begin
    mul_a = xd_q;
    mul_b = yd_q;
    if (cmd_i.mul_sel == PSEL_0) begin
      unique case (mode_q) inside
        MODE_MUL: begin mul_a = xn_q; mul_b = yn_q; end
        MODE_SGN: begin mul_a = xn_q; mul_b = xd_q; end
        default:  begin mul_a = xn_q; mul_b = yd_q; end
      endcase
    end else if (cmd_i.mul_sel == PSEL_1) begin
      unique case (mode_q) inside
        MODE_ADD, MODE_SUB, MODE_CMP: begin mul_a = yn_q; mul_b = xd_q; end
        MODE_DIV:                     begin mul_a = xd_q; mul_b = yn_q; end
        default:                      begin mul_a = xd_q; mul_b = yd_q; end
      endcase
    end
  end

  assign prod = mul_a * mul_b;

  // Product slots, one product per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        PSEL_0:  p0_q <= prod;
        PSEL_1:  p1_q <= prod;
        default: p2_q <= prod;
      endcase
    end
  end

  // Magnitudes of the first fraction for Euclid.
  assign xn_mag = x_num_i[W-1] ? (~x_num_i + 1'b1) : x_num_i;
  assign xd_mag = x_den_i[W-1] ? (~x_den_i + 1'b1) : x_den_i;

  // One restoring remainder bit: shift in the next dividend bit and subtract.
  assign cand     = {rem_q, ash_q[W-1]};
  assign cand_sub = cand - {1'b0, gb_mag_q};
  assign cand_ge  = (cand >= {1'b0, gb_mag_q});

  // Euclid loop registers. The remainder takes the sign of the dividend.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ga_mag_q <= xn_mag;
      ga_neg_q <= x_num_i[W-1];
      gb_mag_q <= xd_mag;
      gb_neg_q <= x_den_i[W-1];
      ash_q    <= xn_mag;
      rem_q    <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= cand_ge ? cand_sub[W-1:0] : cand[W-1:0];
      ash_q <= {ash_q[W-2:0], 1'b0};
    end else if (cmd_i.gcd_next) begin
      ga_mag_q <= gb_mag_q;
      ga_neg_q <= gb_neg_q;
      gb_mag_q <= rem_q;
      gb_neg_q <= ga_neg_q && (rem_q != '0);
      ash_q    <= gb_mag_q;
      rem_q    <= '0;
    end
  end

  // Sign-extended products and their sum and difference, wrapped to the result width.
  assign p0_ext  = {{(SW - PW){p0_q[PW-1]}}, p0_q};
  assign p1_ext  = {{(SW - PW){p1_q[PW-1]}}, p1_q};
  assign p2_ext  = {{(SW - PW){p2_q[PW-1]}}, p2_q};
  assign sum_ext = p0_ext + p1_ext;
  assign dif_ext = p0_ext - p1_ext;

  // Result selection by operation.
  always_comb begin
    num_d     = '0;
    den_d     = '0;
    verdict_d = VERD_NONE;
    unique case (mode_q)
      MODE_ADD: begin
        num_d = sum_ext[RES_W-1:0];
        den_d = p2_ext[RES_W-1:0];
      end
      MODE_SUB: begin
        num_d = dif_ext[RES_W-1:0];
        den_d = p2_ext[RES_W-1:0];
      end
      MODE_MUL, MODE_DIV, MODE_CDN: begin
        num_d = p0_ext[RES_W-1:0];
        den_d = p1_ext[RES_W-1:0];
      end
      MODE_RED: begin
        verdict_d = ((ga_mag_q == W'(1)) && !ga_neg_q) ? VERD_REDUCED : VERD_NOT_REDUCED;
      end
      MODE_SGN: begin
        verdict_d = p0_q[PW-1] ? VERD_NEGATIVE : VERD_NOT_NEG;
      end
      MODE_CMP: begin
        if (p0_q > p1_q) begin
          verdict_d = VERD_GREATER;
        end else if (p0_q < p1_q) begin
          verdict_d = VERD_LESS;
        end else begin
          verdict_d = VERD_EQUAL;
        end
      end
      default: begin
        verdict_d = VERD_NONE;
      end
    endcase
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_num_q <= num_d;
      res_den_q <= den_d;
      verdict_q <= verdict_d;
    end
  end

  // Result strobe, high for one cycle after the finishing step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign done_o    = done_q;
  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign verdict_o = verdict_q;

endmodule

`default_nettype wire

@@ sv/fraction_arithmetic_unit_top.sv @@
// Channel     Direction  Handshake                  Payload
// command     in         start high, busy low       mode_i, x_num_i, x_den_i, y_num_i, y_den_i
// result      out        done_o for one cycle        res_num_o, res_den_o, verdict_o
//
// One transaction at a time. Arithmetic, sign and compare operations form one to three
// products on the shared multiplier, one per step, and then a finishing state registers
// the result and the strobe. The reduced check runs Euclid on a bit-serial remainder
// unit that forms one remainder bit per step.
// Reset clears the controller and the strobe; the receiver cannot stall, and a new
// transaction may be accepted in the cycle that the result strobe is high.
// Top level of the fraction arithmetic unit. Depends on fau_pkg, fau_ctrl and fau_dp.
`timescale 1ns / 1ps
`default_nettype none

module fraction_arithmetic_unit_top #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [2:0]                      mode_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] x_num_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] x_den_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] y_num_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] y_den_i,
  output logic                                 done_o,
  output logic signed [fau_pkg::RES_W-1:0]     res_num_o,
  output logic signed [fau_pkg::RES_W-1:0]     res_den_o,
  output logic [1:0]                           verdict_o
);
  import fau_pkg::*;

  fau_cmd_t  cmd;
  fau_stat_t stat;

  // Controller.
  fau_ctrl #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .mode_i (mode_i),
    .stat_i (stat),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  // Datapath.
  fau_dp #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .mode_i   (mode_i),
    .x_num_i  (x_num_i),
    .x_den_i  (x_den_i),
    .y_num_i  (y_num_i),
    .y_den_i  (y_den_i),
    .stat_o   (stat),
    .done_o   (done_o),
    .res_num_o(res_num_o),
    .res_den_o(res_den_o),
    .verdict_o(verdict_o)
  );

endmodule

`default_nettype wire

@@ bench/fau_result_checker.sv @@
// Result checker of the fraction arithmetic unit: predicts each transaction's result
// and compares it with what the unit delivers. Depends on fau_pkg.
`timescale 1ns / 1ps

module fau_result_checker #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic                              busy,
  input  logic [2:0]                        mode_i,
  input  logic signed [OPERAND_WIDTH-1:0]   x_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]   x_den_i,
  input  logic signed [OPERAND_WIDTH-1:0]   y_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]   y_den_i,
  input  logic                              done_o,
  input  logic signed [fau_pkg::RES_W-1:0]  res_num_o,
  input  logic signed [fau_pkg::RES_W-1:0]  res_den_o,
  input  logic [1:0]                        verdict_o,
  output int unsigned                       error_count,
  output int unsigned                       pending_count
);
  import fau_pkg::*;

  typedef struct packed {
    logic [RES_W-1:0] num;
    logic [RES_W-1:0] den;
    logic [1:0]       verdict;
  } fraction_result_t;

  // Results predicted for accepted transactions, oldest first.
  fraction_result_t awaited_results[$];
  fraction_result_t want;

  // Euclid's recursion with a truncating remainder; the sign of the result is kept.
  function automatic longint euclid_gcd(longint a, longint b);
    longint r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Works out the single result of one transaction from its operands.
  function automatic fraction_result_t predict_fraction_result(
    logic [2:0]                      op,
    logic signed [OPERAND_WIDTH-1:0] xn_f,
    logic signed [OPERAND_WIDTH-1:0] xd_f,
    logic signed [OPERAND_WIDTH-1:0] yn_f,
    logic signed [OPERAND_WIDTH-1:0] yd_f
  );
    longint xn, xd, yn, yd, rn, rd;
    fraction_result_t r;
    xn = longint'(xn_f);
    xd = longint'(xd_f);
    yn = longint'(yn_f);
    yd = longint'(yd_f);
    rn = 0;
    rd = 0;
    r.verdict = VERD_NONE;
    case (mode_e'(op))
      MODE_ADD: begin
        rn = xn * yd + yn * xd;
        rd = xd * yd;
      end
      MODE_SUB: begin
        rn = xn * yd - yn * xd;
        rd = xd * yd;
      end
      MODE_MUL: begin
        rn = xn * yn;
        rd = xd * yd;
      end
      MODE_DIV: begin
        rn = xn * yd;
        rd = xd * yn;
      end
      MODE_CDN: begin
        rn = xn * yd;
        rd = xd * yd;
      end
      MODE_RED: begin
        r.verdict = (euclid_gcd(xn, xd) == 1) ? VERD_REDUCED : VERD_NOT_REDUCED;
      end
      MODE_SGN: begin
        r.verdict = (xn * xd < 0) ? VERD_NEGATIVE : VERD_NOT_NEG;
      end
      default: begin
        // Cross products compared as they stand, whatever the denominators' signs.
        if (xn * yd > yn * xd) r.verdict = VERD_GREATER;
        else if (xn * yd < yn * xd) r.verdict = VERD_LESS;
        else r.verdict = VERD_EQUAL;
      end
    endcase
    r.num = rn[RES_W-1:0];
    r.den = rd[RES_W-1:0];
    return r;
  endfunction

  // Results are retired before a transaction accepted at the same edge is queued.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      awaited_results.delete();
      error_count   = 0;
      pending_count = 0;
    end else begin
      if ($isunknown(done_o)) begin
        $error("done_o is unknown");
        error_count++;
      end else if (done_o) begin
        if (awaited_results.size() == 0) begin
          $error("result strobe with no transaction outstanding");
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (res_num_o !== want.num) begin
            $error("res_num: expected %0d, got %0d", $signed(want.num), res_num_o);
            error_count++;
          end
          if (res_den_o !== want.den) begin
            $error("res_den: expected %0d, got %0d", $signed(want.den), res_den_o);
            error_count++;
          end
          if (verdict_o !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, verdict_o);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        awaited_results = {awaited_results,
          predict_fraction_result(mode_i, x_num_i, x_den_i, y_num_i, y_den_i)};
      end
      pending_count = awaited_results.size();
    end
  end

endmodule

@@ bench/tb_fraction_arithmetic_unit_top.sv @@
// Testbench top of the fraction arithmetic unit: directed and random transactions with
// random gaps, checked by fau_result_checker. Depends on fau_pkg, fau_result_checker and the unit's RTL.
`timescale 1ns / 1ps

module tb_fraction_arithmetic_unit_top;
  import fau_pkg::*;

  localparam int unsigned OW         = 16;
  localparam int unsigned ITEM_COUNT = 1800;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int          OP_MAX     = (2 ** (OW - 1)) - 1;
  localparam int          OP_MIN     = -(2 ** (OW - 1));
  localparam int unsigned OP_SPAN    = (2 ** OW) - 1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [2:0]           mode_i;
  logic signed [OW-1:0] x_num_i;
  logic signed [OW-1:0] x_den_i;
  logic signed [OW-1:0] y_num_i;
  logic signed [OW-1:0] y_den_i;
  logic                 done_o;
  logic signed [RES_W-1:0] res_num_o;
  logic signed [RES_W-1:0] res_den_o;
  logic [1:0]           verdict_o;
  int unsigned          error_count;
  int unsigned          pending_count;
  int unsigned          idle_cycles;

  fraction_arithmetic_unit_top #(
    .OPERAND_WIDTH(OW)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .mode_i   (mode_i),
    .x_num_i  (x_num_i),
    .x_den_i  (x_den_i),
    .y_num_i  (y_num_i),
    .y_den_i  (y_den_i),
    .done_o   (done_o),
    .res_num_o(res_num_o),
    .res_den_o(res_den_o),
    .verdict_o(verdict_o)
  );

  fau_result_checker #(
    .OPERAND_WIDTH(OW)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .x_num_i      (x_num_i),
    .x_den_i      (x_den_i),
    .y_num_i      (y_num_i),
    .y_den_i      (y_den_i),
    .done_o       (done_o),
    .res_num_o    (res_num_o),
    .res_den_o    (res_den_o),
    .verdict_o    (verdict_o),
    .error_count  (error_count),
    .pending_count(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: ends the run when no transaction moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_fraction_arithmetic_unit_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Operands drawn from the extremes, small values and the full range.
  function automatic int pick_operand();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = OP_MIN;
          1: v = OP_MAX;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      1, 2, 3: v = int'($urandom_range(0, 18)) - 9;
      default: v = int'($urandom_range(0, OP_SPAN)) + OP_MIN;
    endcase
    return v;
  endfunction

  // Presents one transaction and returns at the falling edge after it is accepted.
  // While start is low, mode_i, x_num_i and x_den_i carry junk that the unit must ignore.
  task automatic issue_fraction_op(mode_e m, int xn, int xd, int yn, int yd,
                                   int unsigned gap);
    repeat (gap) begin
      start   <= 1'b0;
      mode_i  <= 3'($urandom);
      x_num_i <= OW'($urandom);
      x_den_i <= OW'($urandom);
      @(negedge clk_i);
    end
    start   <= 1'b1;
    mode_i  <= m;
    x_num_i <= OW'(xn);
    x_den_i <= OW'(xd);
    y_num_i <= OW'(yn);
    y_den_i <= OW'(yd);
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    wait (pending_count == 0);
    @(negedge clk_i);
  endtask

  initial begin
    int                   xn, xd, yn, yd;
    int                   k;
    mode_e                m;
    bit                   burst;
    start   = 1'b0;
    mode_i  = '0;
    x_num_i = '0;
    x_den_i = '0;
    y_num_i = '0;
    y_den_i = '0;
    rst_ni  = 1'b0;
    burst   = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: the extremes in the add, subtract, multiply and divide modes, zero denominators.
    issue_fraction_op(MODE_ADD, 32767, 32767, 32767, 32767, 0);
    issue_fraction_op(MODE_ADD, -32768, -32768, -32768, -32768, 0);
    issue_fraction_op(MODE_SUB, 32767, -32768, -32768, 32767, 1);
    issue_fraction_op(MODE_SUB, 5, 0, 3, 0, 0);
    issue_fraction_op(MODE_MUL, -32768, -32768, -32768, 32767, 0);
    issue_fraction_op(MODE_DIV, -32768, 32767, 32767, -32768, 2);
    issue_fraction_op(MODE_DIV, 1, 3, 0, 7, 0);
    issue_fraction_op(MODE_CDN, 5, 0, 3, 7, 0);
    // Reduced check: zero over zero, gcd of minus one, zero denominator, long chain.
    issue_fraction_op(MODE_RED, 0, 0, 1, 1, 0);
    issue_fraction_op(MODE_RED, 1, 1, 0, 0, 0);
    issue_fraction_op(MODE_RED, 6, 4, 0, 0, 3);
    issue_fraction_op(MODE_RED, -1, -1, 0, 0, 0);
    issue_fraction_op(MODE_RED, -3, 4, 0, 0, 0);
    issue_fraction_op(MODE_RED, 1, 0, 0, 0, 0);
    issue_fraction_op(MODE_RED, 28657, 17711, 0, 0, 0);
    issue_fraction_op(MODE_RED, -32768, 32767, 0, 0, 1);
    // Sign: negative either way, both negative, and zero on either side.
    issue_fraction_op(MODE_SGN, -5, 3, 0, 0, 0);
    issue_fraction_op(MODE_SGN, 5, -3, 0, 0, 0);
    issue_fraction_op(MODE_SGN, -5, -3, 0, 0, 0);
    issue_fraction_op(MODE_SGN, 0, -3, 0, 0, 0);
    issue_fraction_op(MODE_SGN, -3, 0, 0, 0, 0);
    // Compare: greater, less, equal, and a negative denominator taken as it stands.
    issue_fraction_op(MODE_CMP, 1, 2, 1, 3, 0);
    issue_fraction_op(MODE_CMP, 1, 3, 1, 2, 0);
    issue_fraction_op(MODE_CMP, 2, 4, 1, 2, 0);
    issue_fraction_op(MODE_CMP, 1, -2, 1, 3, 0);
    drain_results();

    // Random transactions, with back-to-back stretches and occasional full drains.
    for (int unsigned n = 25; n < ITEM_COUNT; n++) begin
      if (n % 64 == 0) burst = ($urandom_range(0, 2) == 0);
      if (n % 400 == 0) drain_results();
      m  = mode_e'($urandom_range(0, 7));
      xn = pick_operand();
      xd = pick_operand();
      yn = pick_operand();
      yd = pick_operand();
      // Scaled copies make equal fractions reachable in the compare mode.
      if (m == MODE_CMP && $urandom_range(0, 3) == 0) begin
        xn = int'($urandom_range(0, 200)) - 100;
        xd = int'($urandom_range(0, 200)) - 100;
        k  = int'($urandom_range(0, 10)) - 5;
        yn = xn * k;
        yd = xd * k;
      end
      issue_fraction_op(m, xn, xd, yn, yd, burst ? 0 : pick_gap());
    end
    start <= 1'b0;

    wait (pending_count == 0);
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && pending_count == 0) begin
      $display("tb_fraction_arithmetic_unit_top: done, clean");
    end else begin
      $display("tb_fraction_arithmetic_unit_top: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/fau_pkg.sv
sv/fau_ctrl.sv
sv/fau_dp.sv
sv/fraction_arithmetic_unit_top.sv
bench/fau_result_checker.sv
bench/tb_fraction_arithmetic_unit_top.sv
